// File: rtl/uer_pkg.sv
// Shared types, register codes and constants of the ultrasonic echo ranger.
package uer_pkg;

	localparam int DIST_W = 13;
	localparam int SHIFT_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int HISTORY_DEPTH_DEF = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd3;

	localparam logic [DIST_W-1:0] TIMEOUT_RST = 13'd7000;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd6;
	localparam logic [DIST_W-1:0] UPPER_RST = 13'd100;
	localparam logic [DIST_W-1:0] LOWER_RST = 13'd10;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	typedef struct packed {
		logic start_measure;
		logic echo_level;
	} in_item_t;

	typedef struct packed {
		logic              trigger_out;
		logic              measure_done;
		logic [DIST_W-1:0] distance;
		logic [DIST_W-1:0] nearest;
		logic              present;
		logic              fault;
		logic              present_changed;
	} out_item_t;

	typedef struct packed {
		logic              trig;
		logic              done;
		logic [DIST_W-1:0] count;
	} uer_evt_t;

	typedef struct packed {
		logic [DIST_W-1:0]  timeout_ticks;
		logic [SHIFT_W-1:0] distance_shift;
		logic [DIST_W-1:0]  upper_threshold;
		logic [DIST_W-1:0]  lower_threshold;
	} uer_cfg_t;

endpackage

// File: rtl/uer_seq.sv
// Measurement sequencer: trigger, wait for echo, and echo high time count.
module uer_seq import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  in_item_t          item,
	input  logic [DIST_W-1:0] timeout_ticks,
	output uer_evt_t          evt
);

	logic [1:0]        phase_q, phase_d;
	logic [DIST_W-1:0] tick_q, tick_d;

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		evt = '0;
		evt.count = tick_q;
		unique case (phase_q)
			PH_WAIT: begin
				if (item.echo_level || tick_q >= timeout_ticks) begin
					tick_d = '0;
					phase_d = PH_HIGH;
				end else begin
					tick_d = tick_q + 1'b1;
				end
			end
			PH_HIGH: begin
				if (item.echo_level && tick_q < timeout_ticks) begin
					tick_d = tick_q + 1'b1;
				end else begin
					evt.done = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.start_measure) begin
					evt.trig = 1'b1;
					tick_d = '0;
					phase_d = PH_WAIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			tick_q <= tick_d;
		end
	end

endmodule

// File: rtl/uer_hist.sv
// Distance history ring, minimum tree and occupancy classification.
module uer_hist import uer_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  uer_evt_t  evt,
	input  uer_cfg_t  cfg,
	output out_item_t result
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int LVL = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0;
	localparam int LEAVES = 1 << LVL;

	logic [DIST_W-1:0] ring_q [HISTORY_DEPTH];
	logic [PTR_W-1:0]  ptr_q, ptr_d;
	logic [DIST_W-1:0] dist_q, min_q;
	logic              pres_q, flt_q;

	logic [DIST_W-1:0] new_dist, new_min;
	logic [DIST_W-1:0] leaf [LEAVES];
	logic [DIST_W-1:0] node [2*LEAVES-1];
	logic              new_pres, new_flt;
	logic              upd;

	assign upd = fire && evt.done;
	assign new_dist = evt.count >> cfg.distance_shift;
	assign ptr_d = (ptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < HISTORY_DEPTH) begin : g_used
			assign leaf[i] = (ptr_d == PTR_W'(i)) ? new_dist : ring_q[i];
		end else begin : g_pad
			assign leaf[i] = '1;
		end
	end

	always_comb begin
		for (int i = 0; i < LEAVES; i++) begin
			node[LEAVES-1+i] = leaf[i];
		end
		for (int k = LEAVES - 2; k >= 0; k--) begin
			node[k] = (node[2*k+2] < node[2*k+1]) ? node[2*k+2] : node[2*k+1];
		end
	end

	assign new_min = node[0];
	assign new_flt = new_min < cfg.lower_threshold;
	assign new_pres = (new_min < cfg.upper_threshold && new_min > cfg.lower_threshold)
		|| new_flt;

	always_comb begin
		result.trigger_out = evt.trig;
		result.measure_done = evt.done;
		if (evt.done) begin
			result.distance = new_dist;
			result.nearest = new_min;
			result.present = new_pres;
			result.fault = new_flt;
			result.present_changed = new_pres != pres_q;
		end else begin
			result.distance = dist_q;
			result.nearest = min_q;
			result.present = pres_q;
			result.fault = flt_q;
			result.present_changed = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else if (upd) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				if (ptr_d == PTR_W'(i)) begin
					ring_q[i] <= new_dist;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			dist_q <= '0;
			min_q <= '0;
			pres_q <= 1'b0;
			flt_q <= 1'b0;
		end else if (upd) begin
			ptr_q <= ptr_d;
			dist_q <= new_dist;
			min_q <= new_min;
			pres_q <= new_pres;
			flt_q <= new_flt;
		end
	end

endmodule

// File: rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: config registers, item register, result buffer.
//
//  Channel  Handshake            Payload      Direction
//  in       in_valid / in_stall  in_data      tick items into the block
//  out      out_valid / out_stall out_data    one result per tick item
//  cfg      cfg_wr_en            cfg_index, cfg_data  register writes, no wait
//
// Items go through item and result registers, one tick per cycle while out_stall is low.
// The rate is set by the single pass from the item register through the sequencer
// and the history minimum tree into the result register.
// Reset clears the sequencer, the history ring and both buffers, and loads register defaults.
// A stalled result holds while one more item waits in the item register.
module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_data
);

	uer_cfg_t  cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      adv, fire, in_xfer;
	uer_evt_t  evt;
	out_item_t result;

	assign adv = !out_valid_q || !out_stall;
	assign fire = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_xfer = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.distance_shift <= SHIFT_RST;
			cfg_q.upper_threshold <= UPPER_RST;
			cfg_q.lower_threshold <= LOWER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				REG_SHIFT:   cfg_q.distance_shift <= cfg_data[SHIFT_W-1:0];
				REG_UPPER:   cfg_q.upper_threshold <= cfg_data;
				REG_LOWER:   cfg_q.lower_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
	end

	uer_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.timeout_ticks (cfg_q.timeout_ticks),
		.evt           (evt)
	);

	uer_hist #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.evt    (evt),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= result;
		end
	end

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while a buffer is free");

	a_changed_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_data_q.present_changed || out_data_q.measure_done))
		else $error("present change reported without a completed measurement");

	a_fault_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_data_q.fault || out_data_q.present))
		else $error("fault reported without present");

	a_trig_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt.trig |=> !(fire && evt.done))
		else $error("measurement completed right after its trigger");

endmodule
